/* hw/rtl/assert_macros.svh */
// Shared assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled during reset.
`define U8SD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define U8SD_NEVER(lbl, clk, rst, cond, msg) \
   `U8SD_ASSERT(lbl, clk, rst, !(cond), msg)

`endif

/* hw/rtl/u8sd_pkg.sv */
package u8sd_pkg;

   localparam int RspDepth = 4;

   localparam logic [7:0] LeadTwoLo   = 8'hC2;
   localparam logic [7:0] LeadTwoHi   = 8'hDF;
   localparam logic [7:0] LeadThreeLo = 8'hE0;
   localparam logic [7:0] LeadThreeHi = 8'hEF;
   localparam logic [7:0] LeadFourLo  = 8'hF0;
   localparam logic [7:0] LeadFourHi  = 8'hF4;
   localparam logic [7:0] LeadSurr    = 8'hED;
   localparam logic [7:0] TrailMinE0  = 8'hA0;
   localparam logic [7:0] TrailMaxEd  = 8'h9F;
   localparam logic [7:0] TrailMinF0  = 8'h90;
   localparam logic [7:0] TrailMaxF4  = 8'h8F;

   typedef struct packed {
      logic        ill_formed;
      logic [20:0] code_point;
      logic [2:0]  span_bytes;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [20:0] partial_value;
      logic [1:0]  trails_left;
      logic [7:0]  first_lead;
      logic [1:0]  bytes_taken;
   } state_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    rsp0;
      rsp_type    rsp1;
      state_type  next;
   } dec_type;

endpackage

/* hw/rtl/u8sd_decode.sv */
module u8sd_decode (
   input  u8sd_pkg::state_type st,
   input  logic [7:0]          byte_in,
   input  logic                end_of_text,
   output u8sd_pkg::dec_type   dec
);
   import u8sd_pkg::*;

   rsp_type     lead_rsp;
   logic        lead_has;
   state_type   lead_state;
   logic        first_ok;
   logic        trail_ok;
   logic [20:0] shifted;
   logic [1:0]  taken_inc;

   // byte decoded as a lead from idle
   always_comb begin
      lead_rsp   = '0;
      lead_has   = 1'b0;
      lead_state = '0;
      lead_rsp.span_bytes = 3'd1;
      if (byte_in[7] == 1'b0) begin
         lead_has            = 1'b1;
         lead_rsp.code_point = {13'd0, byte_in};
      end else if (byte_in >= LeadTwoLo && byte_in <= LeadTwoHi) begin
         lead_state = '{partial_value: {16'd0, byte_in[4:0]}, trails_left: 2'd1,
                        first_lead: byte_in, bytes_taken: 2'd1};
      end else if (byte_in >= LeadThreeLo && byte_in <= LeadThreeHi) begin
         lead_state = '{partial_value: {17'd0, byte_in[3:0]}, trails_left: 2'd2,
                        first_lead: byte_in, bytes_taken: 2'd1};
      end else if (byte_in >= LeadFourLo && byte_in <= LeadFourHi) begin
         lead_state = '{partial_value: {18'd0, byte_in[2:0]}, trails_left: 2'd3,
                        first_lead: byte_in, bytes_taken: 2'd1};
      end else begin
         lead_has            = 1'b1;
         lead_rsp.ill_formed = 1'b1;
      end
      // sequence opened on the final byte: truncated
      if (!lead_has && end_of_text) begin
         lead_has            = 1'b1;
         lead_rsp.ill_formed = 1'b1;
         lead_state          = '0;
      end
   end

   always_comb begin
      priority if (st.first_lead == LeadThreeLo) first_ok = byte_in >= TrailMinE0;
      else if (st.first_lead == LeadSurr)        first_ok = byte_in <= TrailMaxEd;
      else if (st.first_lead == LeadFourLo)      first_ok = byte_in >= TrailMinF0;
      else if (st.first_lead == LeadFourHi)      first_ok = byte_in <= TrailMaxF4;
      else                                       first_ok = 1'b1;
   end

   assign trail_ok  = (byte_in[7:6] == 2'b10) && (st.bytes_taken != 2'd1 || first_ok);
   assign shifted   = {st.partial_value[14:0], byte_in[5:0]};
   assign taken_inc = st.bytes_taken + 2'd1;

   always_comb begin
      dec      = '0;
      dec.next = st;
      if (st.trails_left == 2'd0) begin
         dec.count = {1'b0, lead_has};
         dec.rsp0  = lead_rsp;
         dec.next  = lead_state;
      end else if (trail_ok) begin
         if (st.trails_left == 2'd1) begin
            dec.count           = 2'd1;
            dec.rsp0.code_point = shifted;
            dec.rsp0.span_bytes = {1'b0, st.bytes_taken} + 3'd1;
            dec.next            = '0;
         end else begin
            dec.next = '{partial_value: shifted, trails_left: st.trails_left - 2'd1,
                         first_lead: st.first_lead, bytes_taken: taken_inc};
            if (end_of_text) begin
               dec.count           = 2'd1;
               dec.rsp0.ill_formed = 1'b1;
               dec.rsp0.span_bytes = {1'b0, taken_inc};
               dec.next            = '0;
            end
         end
      end else begin
         // maximal subpart, then the byte is retried as a lead
         dec.rsp0.ill_formed = 1'b1;
         dec.rsp0.span_bytes = {1'b0, st.bytes_taken};
         dec.rsp1            = lead_rsp;
         dec.count           = lead_has ? 2'd2 : 2'd1;
         dec.next            = lead_state;
      end
      dec.rsp0.last_of_run = (dec.count == 2'd1);
      dec.rsp1.last_of_run = 1'b1;
   end

endmodule

/* hw/rtl/u8sd_rspq.sv */
`include "assert_macros.svh"

module u8sd_rspq #(
   parameter int Depth = u8sd_pkg::RspDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        push_n,
   input  u8sd_pkg::rsp_type push0,
   input  u8sd_pkg::rsp_type push1,
   input  logic              pop,
   output u8sd_pkg::rsp_type head,
   output logic              not_empty,
   output logic              room_two
);
   import u8sd_pkg::*;

   localparam int PtrW = (Depth > 2) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   rsp_type             mem [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic [PtrW-1:0]     wr_next;

   function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
      ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
   endfunction

   assign wr_next = ptr_inc(wr_ptr_ff);

   always_comb begin
      unique case (push_n)
         2'd1:    wr_ptr_in = wr_next;
         2'd2:    wr_ptr_in = ptr_inc(wr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
   end

   assign rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
   assign count_in  = count_ff + CntW'(push_n) - CntW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem[wr_ptr_ff] <= push0;
      end
      if (push_n == 2'd2) begin
         mem[wr_next] <= push1;
      end
   end

   assign head      = mem[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign room_two  = (count_ff <= CntW'(Depth - 2));

   `U8SD_ASSERT(a_count_max, clock, reset, count_ff <= CntW'(Depth), "queue count over depth")
   `U8SD_ASSERT(a_push_room, clock, reset, (push_n != 2'd0) |-> room_two, "push without room")
   `U8SD_NEVER(a_pop_empty, clock, reset, pop && !not_empty, "pop from empty queue")

endmodule

/* hw/rtl/strict_utf8_stream_decoder.sv */
// Channel | Ports                               | Direction
// req     | req_valid/ready, byte_in, end_of_text | in, one byte per beat
// rsp     | rsp_valid/ready, ill_formed, code_point, span_bytes, last_of_run | out
//
// One byte accepted per cycle while req_ready is high; decode is a single
// combinational pass from the sequence state register into a result queue of
// RspDepth entries. A byte can yield 0, 1 or 2 results; req_ready needs room for
// two in the queue. Results pass through the queue registers to rsp.
// Synchronous active-high reset returns the decoder to idle and empties the queue.
// A stalled rsp side backs up into req_ready once the queue is nearly full.
`include "assert_macros.svh"

module strict_utf8_stream_decoder #(
   parameter int RspDepth = u8sd_pkg::RspDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_in,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_ill_formed,
   output logic [20:0] rsp_code_point,
   output logic [2:0]  rsp_span_bytes,
   output logic        rsp_last_of_run
);
   import u8sd_pkg::*;

   state_type state_ff, state_in;
   dec_type   dec;
   rsp_type   head;
   logic      accept;
   logic      room_two;

   u8sd_decode u_decode (
      .st          (state_ff),
      .byte_in     (req_byte_in),
      .end_of_text (req_end_of_text),
      .dec         (dec)
   );

   assign req_ready = room_two;
   assign accept    = req_valid && req_ready;
   assign state_in  = accept ? dec.next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   u8sd_rspq #(.Depth(RspDepth)) u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push_n    (accept ? dec.count : 2'd0),
      .push0     (dec.rsp0),
      .push1     (dec.rsp1),
      .pop       (rsp_valid && rsp_ready),
      .head      (head),
      .not_empty (rsp_valid),
      .room_two  (room_two)
   );

   assign rsp_ill_formed  = head.ill_formed;
   assign rsp_code_point  = head.code_point;
   assign rsp_span_bytes  = head.span_bytes;
   assign rsp_last_of_run = head.last_of_run;

   `U8SD_ASSERT(a_idle_clean, clock, reset, (state_ff.trails_left == 2'd0) |-> (state_ff.bytes_taken == 2'd0), "idle with bytes taken")
   `U8SD_ASSERT(a_pair_order, clock, reset, (dec.count == 2'd2) |-> (dec.rsp0.ill_formed && !dec.rsp0.last_of_run), "bad result pair")
   `U8SD_ASSERT(a_ill_zero, clock, reset, (rsp_valid && rsp_ill_formed) |-> (rsp_code_point == 21'd0), "ill-formed beat carries code point")
   `U8SD_ASSERT(a_span_range, clock, reset, rsp_valid |-> (rsp_span_bytes != 3'd0 && rsp_span_bytes <= 3'd4), "span out of range")

endmodule

/* test/utf8_decode_checker.sv */
`timescale 1ns / 1ps

module utf8_decode_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_byte_in,
   input  logic        req_end_of_text,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_ill_formed,
   input  logic [20:0] rsp_code_point,
   input  logic [2:0]  rsp_span_bytes,
   input  logic        rsp_last_of_run,
   output int          mismatches,
   output int          awaited
);
   import u8sd_pkg::*;

   state_type open_seq;
   rsp_type   produced[$];
   rsp_type   awaited_decodes[$];

   initial begin
      mismatches = 0;
      awaited = 0;
      open_seq = '0;
   end

   function automatic void note(input logic bad, input logic [20:0] cp, input logic [2:0] span);
      rsp_type r;
      r.ill_formed  = bad;
      r.code_point  = bad ? 21'd0 : cp;
      r.span_bytes  = span;
      r.last_of_run = 1'b0;
      produced.push_back(r);
   endfunction

   function automatic void take_lead(input logic [7:0] b, input logic eot);
      if (b < 8'h80) begin
         note(1'b0, {13'd0, b}, 3'd1);
      end else if (b >= LeadTwoLo && b <= LeadFourHi) begin
         if (b <= LeadTwoHi) begin
            open_seq.trails_left   = 2'd1;
            open_seq.partial_value = {16'd0, b[4:0]};
         end else if (b <= LeadThreeHi) begin
            open_seq.trails_left   = 2'd2;
            open_seq.partial_value = {17'd0, b[3:0]};
         end else begin
            open_seq.trails_left   = 2'd3;
            open_seq.partial_value = {18'd0, b[2:0]};
         end
         open_seq.first_lead  = b;
         open_seq.bytes_taken = 2'd1;
         if (eot) begin
            open_seq = '0;
            note(1'b1, 21'd0, 3'd1);
         end
      end else begin
         note(1'b1, 21'd0, 3'd1);
      end
   endfunction

   function automatic logic trail_fits(input logic [7:0] b);
      logic [7:0] lead;
      lead = open_seq.first_lead;
      if (b[7:6] != 2'b10)
         return 1'b0;
      if (open_seq.bytes_taken != 2'd1)
         return 1'b1;
      return !((lead == LeadThreeLo && b < TrailMinE0) ||
               (lead == LeadSurr    && b > TrailMaxEd) ||
               (lead == LeadFourLo  && b < TrailMinF0) ||
               (lead == LeadFourHi  && b > TrailMaxF4));
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic eot);
      produced.delete();
      if (open_seq.trails_left == 2'd0) begin
         take_lead(b, eot);
      end else if (trail_fits(b)) begin
         open_seq.partial_value = {open_seq.partial_value[14:0], b[5:0]};
         open_seq.trails_left   = open_seq.trails_left - 2'd1;
         if (open_seq.trails_left == 2'd0) begin
            note(1'b0, open_seq.partial_value, 3'(open_seq.bytes_taken) + 3'd1);
            open_seq = '0;
         end else begin
            open_seq.bytes_taken = open_seq.bytes_taken + 2'd1;
            if (eot) begin
               note(1'b1, 21'd0, 3'(open_seq.bytes_taken));
               open_seq = '0;
            end
         end
      end else begin
         // broken sequence: report the maximal subpart, then retry the byte as a lead
         note(1'b1, 21'd0, 3'(open_seq.bytes_taken));
         open_seq = '0;
         take_lead(b, eot);
      end
      if (produced.size() > 0)
         produced[produced.size() - 1].last_of_run = 1'b1;
      foreach (produced[i])
         awaited_decodes.push_back(produced[i]);
   endfunction

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         open_seq = '0;
         awaited_decodes.delete();
      end else begin
         if (req_valid && req_ready)
            decode_byte(req_byte_in, req_end_of_text);
         if (rsp_valid && rsp_ready) begin
            if (awaited_decodes.size() == 0) begin
               $error("unexpected result: ill_formed %0b code_point %0h span %0d",
                      rsp_ill_formed, rsp_code_point, rsp_span_bytes);
               mismatches++;
            end else begin
               want = awaited_decodes.pop_front();
               compare_field("ill_formed", 32'(want.ill_formed), 32'(rsp_ill_formed));
               compare_field("code_point", 32'(want.code_point), 32'(rsp_code_point));
               compare_field("span_bytes", 32'(want.span_bytes), 32'(rsp_span_bytes));
               compare_field("last_of_run", 32'(want.last_of_run), 32'(rsp_last_of_run));
            end
         end
      end
      awaited = awaited_decodes.size();
   end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import u8sd_pkg::*;

   localparam int RandomBeats = 1200;
   localparam int CycleLimit  = 400000;
   localparam int LongHold    = 300;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_byte_in;
   logic        req_end_of_text;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_ill_formed;
   logic [20:0] rsp_code_point;
   logic [2:0]  rsp_span_bytes;
   logic        rsp_last_of_run;

   int          mismatches;
   int          awaited;
   int          cycle_count;
   int          beats_sent;
   logic        calm;
   logic        hold_request;
   int          stall_left;
   logic [7:0]  text[$];

   strict_utf8_stream_decoder dut (.*);

   utf8_decode_checker decode_watch (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock)
      cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count == CycleLimit);
      $display("testbench: FAIL");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // receiver: random stalls, one long hold-off on request, no new stalls while calm
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LongHold - 1) @(negedge clock);
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
               stall_left = pick_gap();
         end
      end
   end

   task automatic send_beat(input logic [7:0] b, input logic eot);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_byte_in     <= b;
      req_end_of_text <= eot;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
   endtask

   task automatic send_text(input logic eot_last);
      foreach (text[i])
         send_beat(text[i], eot_last && i == text.size() - 1);
      text.delete();
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (awaited == 0);
   endtask

   function automatic void encode_point(input int len);
      logic [20:0] cp;
      case (len)
         1: begin
            cp = 21'($urandom_range(0, 'h7F));
            text.push_back(cp[7:0]);
         end
         2: begin
            cp = 21'($urandom_range('h80, 'h7FF));
            text.push_back({3'b110, cp[10:6]});
            text.push_back({2'b10, cp[5:0]});
         end
         3: begin
            do cp = 21'($urandom_range('h800, 'hFFFF));
            while (cp >= 'hD800 && cp <= 'hDFFF);
            text.push_back({4'b1110, cp[15:12]});
            text.push_back({2'b10, cp[11:6]});
            text.push_back({2'b10, cp[5:0]});
         end
         default: begin
            cp = 21'($urandom_range('h10000, 'h10FFFF));
            text.push_back({5'b11110, cp[20:18]});
            text.push_back({2'b10, cp[17:12]});
            text.push_back({2'b10, cp[11:6]});
            text.push_back({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   task automatic send_random_sequence();
      int kind;
      int len;
      int keep;
      int extra;
      logic [7:0] lead;
      kind = $urandom_range(0, 99);
      len  = $urandom_range(1, 4);
      if (kind < 70) begin
         encode_point(len);
         send_text($urandom_range(0, 19) == 0);
      end else if (kind < 80) begin
         text.push_back(8'($urandom_range(0, 255)));
         send_text($urandom_range(0, 7) == 0);
      end else if (kind < 90) begin
         encode_point(len);
         keep = (len > 1) ? $urandom_range(1, len - 1) : 1;
         while (text.size() > keep) void'(text.pop_back());
         if ($urandom_range(0, 1) == 0) begin
            send_text(1'b1);
         end else begin
            text.push_back(8'($urandom_range(0, 255)));
            send_text($urandom_range(0, 7) == 0);
         end
      end else begin
         // restricted lead followed by an out-of-range first trail
         case ($urandom_range(0, 3))
            0: begin lead = LeadThreeLo; text.push_back(lead);
               text.push_back(8'($urandom_range('h80, 'h9F))); end
            1: begin lead = LeadSurr; text.push_back(lead);
               text.push_back(8'($urandom_range('hA0, 'hBF))); end
            2: begin lead = LeadFourLo; text.push_back(lead);
               text.push_back(8'($urandom_range('h80, 'h8F))); end
            default: begin lead = LeadFourHi; text.push_back(lead);
               text.push_back(8'($urandom_range('h90, 'hBF))); end
         endcase
         extra = $urandom_range(0, 2);
         repeat (extra) text.push_back(8'($urandom_range('h80, 'hBF)));
         send_text($urandom_range(0, 7) == 0);
      end
   endtask

   initial begin
      int directed_beats;
      int seq_index;
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_byte_in     = 8'h00;
      req_end_of_text = 1'b0;
      rsp_ready       = 1'b0;
      cycle_count     = 0;
      beats_sent      = 0;
      calm            = 1'b0;
      hold_request    = 1'b0;
      stall_left      = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      text = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80, 8'hED, 8'h9F, 8'hBF,
               8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hF0, 8'h90, 8'h80, 8'h80,
               8'h80, 8'hC0, 8'hFF, 8'hED, 8'hA0, 8'hC2, 8'h41};
      send_text(1'b0);
      // truncated text ends inside a three-byte sequence
      text = '{8'hE1, 8'h80};
      send_text(1'b1);
      directed_beats = beats_sent;
      drain();

      seq_index = 0;
      while (beats_sent < directed_beats + RandomBeats) begin
         if (seq_index == 150)
            hold_request = 1'b1;
         if (seq_index == 250)
            drain();
         calm = (seq_index >= 300 && seq_index < 360);
         send_random_sequence();
         seq_index++;
      end
      calm = 1'b0;

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

/* strict_utf8_stream_decoder.f */
+incdir+hw/rtl
hw/rtl/u8sd_pkg.sv
hw/rtl/u8sd_decode.sv
hw/rtl/u8sd_rspq.sv
hw/rtl/strict_utf8_stream_decoder.sv
test/utf8_decode_checker.sv
test/testbench.sv
